FILE: rtl/core/tlb_page_table_translator_macros.svh
// ----------------------------------------------------------------------------
// TLB translator assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tpt_pkg.sv
// ----------------------------------------------------------------------------
// TLB translator package
// Widths, sizes, state codes and the structs passed between the modules.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int ADDR_W       = 16;
    localparam int PAGE_ENTRIES = 256;
    localparam int TLB_ENTRIES  = 16;
    localparam int FRAME_BYTES  = 256;
    localparam int CNT_W        = 32;

    localparam int OFFSET_W  = $clog2(FRAME_BYTES);
    localparam int PAGE_W    = $clog2(PAGE_ENTRIES);
    localparam int FRAME_W   = PAGE_W;
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    localparam int FREE_W    = PAGE_W + 1;

    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [PAGE_W-1:0]    t_page;
    typedef logic [OFFSET_W-1:0]  t_offset;
    typedef logic [FRAME_W-1:0]   t_frame;
    typedef logic [TLB_IDX_W-1:0] t_tlb_idx;
    typedef logic [FREE_W-1:0]    t_free;
    typedef logic [CNT_W-1:0]     t_count;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    typedef struct packed {
        logic   hit;
        t_frame frame;
    } t_tlb_look;

    typedef struct packed {
        logic   en;
        t_page  page;
        t_frame frame;
    } t_tlb_fill;

endpackage

FILE: rtl/core/tpt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tpt_tlb.sv
// ----------------------------------------------------------------------------
// TLB array
// Fully associative tag compare over all entries, lowest matching entry wins,
// and replacement in first-in first-out order.
// ----------------------------------------------------------------------------
module tpt_tlb (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpt_pkg::t_page    i_page,
    input  tpt_pkg::t_tlb_fill i_fill,
    output tpt_pkg::t_tlb_look o_look
);

    import tpt_pkg::*;

    t_page            r_tag   [TLB_ENTRIES];
    t_frame           r_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;
    t_tlb_idx         r_ptr;
    t_tlb_idx         n_ptr;

    always_comb begin
        o_look = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == i_page)) begin
                o_look.hit   = 1'b1;
                o_look.frame = r_frame[i];
            end
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_fill.en) begin
            if (r_ptr == t_tlb_idx'(TLB_ENTRIES - 1)) begin
                n_ptr = '0;
            end else begin
                n_ptr = r_ptr + t_tlb_idx'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else begin
            r_ptr <= n_ptr;
            if (i_fill.en) begin
                r_valid[r_ptr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fill.en) begin
            r_tag[r_ptr]   <= i_fill.page;
            r_frame[r_ptr] <= i_fill.frame;
        end
    end

endmodule

FILE: rtl/core/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// TLB and page table address translator
// Translates a logical address through a TLB backed by a page table memory,
// allocating frames on page faults and counting hits and faults.
//
//   Channel  Signals                          Direction  Content
//   input    i_valid / o_ready                in         logical address
//   output   o_valid / i_ready                out        address, flags, counts
//
// The accept cycle issues the page table read, and the next cycle compares
// the TLB, resolves the entry and updates state.
// The registered read port of the page table sets this split.
// Reset is synchronous and clears control state and the page valid bits at once.
// A held result stalls the lookup cycle, so no item is resolved until it goes.
// ----------------------------------------------------------------------------
`include "tlb_page_table_translator_macros.svh"

module tlb_page_table_translator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [15:0]            i_logical_address,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [15:0]            o_physical_address,
    output logic                   o_tlb_hit,
    output logic                   o_fault_flag,
    output logic [31:0]            o_hit_count,
    output logic [31:0]            o_fault_count
);

    import tpt_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_addr      r_addr;
    t_free      r_next_free;
    t_free      n_next_free;
    t_count     r_hit_total;
    t_count     n_hit_total;
    t_count     r_fault_total;
    t_count     n_fault_total;
    logic [PAGE_ENTRIES-1:0] r_pt_valid;
    logic       r_out_valid;
    t_addr      r_out_addr;
    logic       r_out_hit;
    logic       r_out_fault;

    t_page      c_page;
    t_offset    c_offset;
    t_page      c_raddr;
    t_frame     c_ram_rdata;
    t_tlb_look  c_look;
    t_tlb_fill  c_fill;
    logic       c_pt_valid;
    logic       c_fault;
    logic       c_commit;
    t_frame     c_frame;

    assign c_page   = r_addr[OFFSET_W +: PAGE_W];
    assign c_offset = r_addr[OFFSET_W-1:0];
    assign c_raddr  = (r_state == S_IDLE) ? i_logical_address[OFFSET_W +: PAGE_W] : c_page;

    tpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PAGE_ENTRIES)
    ) u_page_table (
        .i_clk   (i_clk),
        .i_we    (c_commit && c_fault),
        .i_waddr (c_page),
        .i_wdata (r_next_free[FRAME_W-1:0]),
        .i_raddr (c_raddr),
        .o_rdata (c_ram_rdata)
    );

    tpt_tlb u_tlb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_page  (c_page),
        .i_fill  (c_fill),
        .o_look  (c_look)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign c_pt_valid = r_pt_valid[c_page];
    assign c_fault    = !c_look.hit && !c_pt_valid;
    assign c_commit   = (r_state == S_LOOK) && (!r_out_valid || i_ready);

    always_comb begin
        if (c_look.hit) begin
            c_frame = c_look.frame;
        end else if (c_pt_valid) begin
            c_frame = c_ram_rdata;
        end else begin
            c_frame = r_next_free[FRAME_W-1:0];
        end
    end

    always_comb begin
        c_fill.en    = c_commit && !c_look.hit;
        c_fill.page  = c_page;
        c_fill.frame = c_frame;
    end

    always_comb begin
        n_state       = r_state;
        n_next_free   = r_next_free;
        n_hit_total   = r_hit_total;
        n_fault_total = r_fault_total;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (c_commit) begin
                    n_state = S_IDLE;
                    if (c_look.hit) begin
                        n_hit_total = r_hit_total + t_count'(1);
                    end
                    if (c_fault) begin
                        n_fault_total = r_fault_total + t_count'(1);
                        if (r_next_free < t_free'(PAGE_ENTRIES)) begin
                            n_next_free = r_next_free + t_free'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_next_free   <= '0;
            r_hit_total   <= '0;
            r_fault_total <= '0;
            r_pt_valid    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_next_free   <= n_next_free;
            r_hit_total   <= n_hit_total;
            r_fault_total <= n_fault_total;
            if (c_commit && c_fault) begin
                r_pt_valid[c_page] <= 1'b1;
            end
            if (c_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_addr <= i_logical_address;
        end
        if (c_commit) begin
            r_out_addr  <= t_addr'({c_frame, c_offset});
            r_out_hit   <= c_look.hit;
            r_out_fault <= c_fault;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_physical_address = r_out_addr;
    assign o_tlb_hit          = r_out_hit;
    assign o_fault_flag       = r_out_fault;
    assign o_hit_count        = r_hit_total;
    assign o_fault_count      = r_fault_total;

    `TPT_ASSERT_NEXT(a_accept_to_look, i_valid && o_ready, r_state == S_LOOK,
        "Accepted item did not enter the lookup cycle.")
    `TPT_ASSERT_SAME(a_hit_no_fault, o_valid, !(o_tlb_hit && o_fault_flag),
        "Result flags a TLB hit and a page fault together.")
    `TPT_ASSERT_SAME(a_free_bound, 1'b1, r_next_free <= t_free'(PAGE_ENTRIES),
        "Next free frame ran past the page table size.")
    `TPT_ASSERT_NEXT(a_fault_counts, c_commit && c_fault,
        r_fault_total == $past(r_fault_total) + t_count'(1),
        "Page fault did not advance the fault count.")

endmodule
